// ===== design/weighted_outer_product_cov3x3_defines.svh =====
// ---------------------------------------------------------------------------
// Covariance accumulator assertion macros
// Shared concurrent assertion forms for the covariance accumulator.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_OUTER_PRODUCT_COV3X3_DEFINES_SVH
`define WEIGHTED_OUTER_PRODUCT_COV3X3_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define WOPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wopc: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define WOPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wopc: next-cycle check failed");

`endif

// ===== design/wopc_pkg.sv =====
// ---------------------------------------------------------------------------
// wopc_pkg
// Types, widths and the saturating add of the covariance accumulator.
// ---------------------------------------------------------------------------
package wopc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int SUM_BITS    = 56;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIFF_BITS;
  localparam int TERM_BITS   = PROD_BITS + WEIGHT_BITS;
  localparam int ADD_BITS    = ((TERM_BITS > SUM_BITS) ? TERM_BITS : SUM_BITS) + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADD_BITS-1:0] SAT_HI =
    {{(ADD_BITS - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
  localparam logic [ADD_BITS-1:0] SAT_LO = ~SAT_HI;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [TERM_BITS-1:0]  term_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  typedef enum logic {
    OP_CENTRE    = 1'b0,
    OP_NEIGHBOUR = 1'b1
  } op_t;

  typedef struct packed {
    logic                          op;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic signed [COORD_BITS-1:0]  def_x;
    logic signed [COORD_BITS-1:0]  def_y;
    logic signed [COORD_BITS-1:0]  def_z;
    logic signed [COORD_BITS-1:0]  rest_x;
    logic signed [COORD_BITS-1:0]  rest_y;
    logic signed [COORD_BITS-1:0]  rest_z;
    logic                          last;
  } in_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] s00;
    logic signed [SUM_BITS-1:0] s01;
    logic signed [SUM_BITS-1:0] s02;
    logic signed [SUM_BITS-1:0] s10;
    logic signed [SUM_BITS-1:0] s11;
    logic signed [SUM_BITS-1:0] s12;
    logic signed [SUM_BITS-1:0] s20;
    logic signed [SUM_BITS-1:0] s21;
    logic signed [SUM_BITS-1:0] s22;
  } out_t;

  // Command handed from the front part to the back part.
  typedef struct packed {
    op_t                           kind;
    logic                          last;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic [2:0][DIFF_BITS-1:0]     dd;
    logic [2:0][DIFF_BITS-1:0]     dr;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PROD,
    BK_WGT,
    BK_ACC,
    BK_EMIT
  } back_state_t;

  // Exact add, then clamp to the sum range.
  function automatic sum_t sat_add(sum_t a, term_t b);
    logic signed [ADD_BITS-1:0] s;
    s = ADD_BITS'(a) + ADD_BITS'(b);
    if (s > $signed(SAT_HI)) begin
      return SUM_BITS'(SAT_HI);
    end else if (s < $signed(SAT_LO)) begin
      return SUM_BITS'(SAT_LO);
    end
    return SUM_BITS'(s);
  endfunction

endpackage

// ===== design/weighted_outer_product_cov3x3.sv =====
// ---------------------------------------------------------------------------
// weighted_outer_product_cov3x3
// 3x3 weighted covariance accumulator for one vertex: centre items load and
// clear, neighbour items add weight times the outer product of differences.
// ---------------------------------------------------------------------------
// channel   ports                   beat taken when
// input     push, full, item        push && !full
// result    empty, pop, result      pop && !empty
//
// In the back part a neighbour beat pops the command, then runs three rows through a
// shared three-lane unit of product, weighting and saturating add. A centre beat is
// only popped there; a last beat then passes through EMIT to load the result register.
// The front part takes a beat per cycle while the four-entry queue has room.
// Reset (rst, synchronous) clears centre positions, sums and the queue.
// A result waiting on the port stalls the back part only when another matrix is ready.
// ---------------------------------------------------------------------------
module weighted_outer_product_cov3x3 (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  wopc_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output wopc_pkg::out_t result
);

  logic           q_full;
  logic           q_push;
  logic           q_empty;
  logic           q_pop;
  wopc_pkg::cmd_t wr_cmd;
  wopc_pkg::cmd_t rd_cmd;

  wopc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (wr_cmd)
  );

  wopc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_cmd  (wr_cmd),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_cmd  (rd_cmd),
    .q_empty (q_empty)
  );

  wopc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (rd_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== design/wopc_front.sv =====
// ---------------------------------------------------------------------------
// wopc_front
// Accepts items, latches centre positions and forms the difference command.
// ---------------------------------------------------------------------------
module wopc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  wopc_pkg::in_t  item,
  input  logic           q_full,
  output logic           q_push,
  output wopc_pkg::cmd_t q_cmd
);

  wopc_pkg::coord_t centre_def  [3];
  wopc_pkg::coord_t centre_rest [3];
  logic             accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        centre_def[i]  <= '0;
        centre_rest[i] <= '0;
      end
    end else if (accept && (item.op == wopc_pkg::OP_CENTRE)) begin
      centre_def[0]  <= item.def_x;
      centre_def[1]  <= item.def_y;
      centre_def[2]  <= item.def_z;
      centre_rest[0] <= item.rest_x;
      centre_rest[1] <= item.rest_y;
      centre_rest[2] <= item.rest_z;
    end
  end

  // centre minus neighbour, one bit wider than a coordinate
  always_comb begin
    q_cmd.kind   = wopc_pkg::op_t'(item.op);
    q_cmd.last   = item.last;
    q_cmd.weight = item.weight;
    q_cmd.dd[0]  = wopc_pkg::DIFF_BITS'(centre_def[0])  - wopc_pkg::DIFF_BITS'(item.def_x);
    q_cmd.dd[1]  = wopc_pkg::DIFF_BITS'(centre_def[1])  - wopc_pkg::DIFF_BITS'(item.def_y);
    q_cmd.dd[2]  = wopc_pkg::DIFF_BITS'(centre_def[2])  - wopc_pkg::DIFF_BITS'(item.def_z);
    q_cmd.dr[0]  = wopc_pkg::DIFF_BITS'(centre_rest[0]) - wopc_pkg::DIFF_BITS'(item.rest_x);
    q_cmd.dr[1]  = wopc_pkg::DIFF_BITS'(centre_rest[1]) - wopc_pkg::DIFF_BITS'(item.rest_y);
    q_cmd.dr[2]  = wopc_pkg::DIFF_BITS'(centre_rest[2]) - wopc_pkg::DIFF_BITS'(item.rest_z);
  end

endmodule

// ===== design/wopc_queue.sv =====
// ---------------------------------------------------------------------------
// wopc_queue
// Short command queue between the front and back parts.
// ---------------------------------------------------------------------------
`include "weighted_outer_product_cov3x3_defines.svh"

module wopc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  wopc_pkg::cmd_t wr_cmd,
  output logic           q_full,
  input  logic           rd,
  output wopc_pkg::cmd_t rd_cmd,
  output logic           q_empty
);

  wopc_pkg::cmd_t                   mem [wopc_pkg::QUEUE_DEPTH];
  logic [wopc_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [wopc_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [wopc_pkg::QCNT_BITS-1:0]   count;
  logic                             do_wr;
  logic                             do_rd;

  assign q_full  = (count == wopc_pkg::QCNT_BITS'(wopc_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_cmd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == wopc_pkg::QPTR_BITS'(wopc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == wopc_pkg::QPTR_BITS'(wopc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `WOPC_ASSERT_NOW(a_count_bound, clk, rst, 1'b1,
                   count <= wopc_pkg::QCNT_BITS'(wopc_pkg::QUEUE_DEPTH))
  `WOPC_ASSERT_NEXT(a_fill_tracks, clk, rst, do_wr && !do_rd, !q_empty)
  `WOPC_ASSERT_NEXT(a_drain_tracks, clk, rst, do_rd && !do_wr, !q_full)

endmodule

// ===== design/wopc_back.sv =====
// ---------------------------------------------------------------------------
// wopc_back
// Runs commands: clears the nine sums or accumulates them a row at a time and
// hands finished matrices to the result register.
// ---------------------------------------------------------------------------
`include "weighted_outer_product_cov3x3_defines.svh"

module wopc_back (
  input  logic           clk,
  input  logic           rst,
  input  wopc_pkg::cmd_t q_cmd,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output wopc_pkg::out_t result
);

  wopc_pkg::back_state_t state;
  wopc_pkg::back_state_t state_next;
  wopc_pkg::cmd_t        cmd;
  logic [1:0]            row;
  wopc_pkg::prod_t       prod [3];
  wopc_pkg::term_t       term [3];
  wopc_pkg::sum_t        acc  [3][3];
  logic                  res_valid;
  logic                  res_load;
  logic                  row_done;

  assign row_done = (row == 2'd2);
  assign empty    = !res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      wopc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind == wopc_pkg::OP_NEIGHBOUR) begin
            state_next = wopc_pkg::BK_PROD;
          end else if (q_cmd.last) begin
            state_next = wopc_pkg::BK_EMIT;
          end
        end
      end
      wopc_pkg::BK_PROD: state_next = wopc_pkg::BK_WGT;
      wopc_pkg::BK_WGT:  state_next = wopc_pkg::BK_ACC;
      wopc_pkg::BK_ACC: begin
        if (!row_done) begin
          state_next = wopc_pkg::BK_PROD;
        end else if (cmd.last) begin
          state_next = wopc_pkg::BK_EMIT;
        end else begin
          state_next = wopc_pkg::BK_IDLE;
        end
      end
      wopc_pkg::BK_EMIT: begin
        if (!res_valid || pop) begin
          state_next = wopc_pkg::BK_IDLE;
        end
      end
      default: state_next = wopc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == wopc_pkg::BK_IDLE) && !q_empty;
    res_load = (state == wopc_pkg::BK_EMIT) && (!res_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wopc_pkg::BK_IDLE;
      row       <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc[i][j] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      if (q_pop) begin
        row <= '0;
        if (q_cmd.kind == wopc_pkg::OP_CENTRE) begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              acc[i][j] <= '0;
            end
          end
        end
      end
      if (state == wopc_pkg::BK_ACC) begin
        for (int j = 0; j < 3; j++) begin
          acc[row][j] <= wopc_pkg::sat_add(acc[row][j], term[j]);
        end
        if (!row_done) begin
          row <= row + 1'b1;
        end
      end
    end
  end

  // datapath: one row of three lanes, product then weighting
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (state == wopc_pkg::BK_PROD) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= wopc_pkg::PROD_BITS'($signed(cmd.dd[row])) *
                   wopc_pkg::PROD_BITS'($signed(cmd.dr[j]));
      end
    end
    if (state == wopc_pkg::BK_WGT) begin
      for (int j = 0; j < 3; j++) begin
        term[j] <= wopc_pkg::TERM_BITS'(prod[j]) * wopc_pkg::TERM_BITS'(cmd.weight);
      end
    end
    if (res_load) begin
      result.s00 <= acc[0][0];
      result.s01 <= acc[0][1];
      result.s02 <= acc[0][2];
      result.s10 <= acc[1][0];
      result.s11 <= acc[1][1];
      result.s12 <= acc[1][2];
      result.s20 <= acc[2][0];
      result.s21 <= acc[2][1];
      result.s22 <= acc[2][2];
    end
  end

  `WOPC_ASSERT_NOW(a_row_range, clk, rst, 1'b1, row != 2'd3)
  `WOPC_ASSERT_NEXT(a_centre_clears, clk, rst,
                    q_pop && (q_cmd.kind == wopc_pkg::OP_CENTRE),
                    acc[0][0] == '0 && acc[1][1] == '0 && acc[2][2] == '0)
  `WOPC_ASSERT_NEXT(a_emit_fills, clk, rst, res_load, res_valid)
  `WOPC_ASSERT_NOW(a_pop_idle_only, clk, rst, state != wopc_pkg::BK_IDLE, !q_pop)

endmodule
